FILE: hw/rtl/pdc_pkg.sv
// Shared types and constants for the PWM period and duty capture block.
// No dependencies; every other file in hw/rtl imports this package.
package pdc_pkg;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT_MULT = 1'b0;
  localparam logic CFG_MIN_TIMEOUT  = 1'b1;

  // Register reset values.
  localparam logic [7:0]  MULT_RESET = 8'd4;
  localparam logic [31:0] MIN_RESET  = 32'h0001_0000;

  // Duty value that means 100 percent.
  localparam logic [16:0] DUTY_ONE = 17'h1_0000;

  // Number of quotient bits the divider develops when high time is below the period.
  localparam int DIV_STEPS = 16;

  // Number of multiplier bits the window unit consumes, one per cycle.
  localparam int MULT_BITS = 8;

  // Input word kinds carried in the mode bit.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WSTART,
    S_WIN,
    S_EMIT,
    S_TICK,
    S_SCAN
  } state_t;

endpackage

FILE: hw/rtl/pdc_div.sv
// Serial restoring divider for the Q16 duty value: one quotient bit per cycle.
// Depends on pdc_pkg for the duty constants.
module pdc_div import pdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [16:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [15:0] q;
  logic [32:0] rem_shift;
  logic        take;
  logic [31:0] rem_next;
  logic [15:0] q_next;

  // One restoring step: shift in a zero and subtract when the divisor fits.
  always_comb begin
    rem_shift = {rem, 1'b0};
    take      = (rem_shift >= {1'b0, dvs});
    rem_next  = take ? 32'(rem_shift - {1'b0, dvs}) : rem_shift[31:0];
    q_next    = {q[14:0], take};
  end

  // Start decides the saturated and zero cases at once; otherwise iterate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvs <= divisor;
        rem <= dividend;
        q   <= '0;
        if (divisor == 32'd0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (dividend >= divisor) begin
          quot <= DUTY_ONE;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 5'(DIV_STEPS);
        end
      end else if (busy) begin
        rem <= rem_next;
        q   <= q_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= {1'b0, q_next};
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pdc_window.sv
// Serial shift-add multiplier that forms the clamped timeout window.
// Depends on pdc_pkg for the multiplier width.
module pdc_window import pdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] period,
  input  logic [7:0]  mult,
  input  logic [31:0] min_ticks,
  output logic        done,
  output logic [31:0] window
);

  logic        busy;
  logic [3:0]  cnt;
  logic [31:0] base;
  logic [7:0]  mreg;
  logic [39:0] acc;
  logic [39:0] acc_next;

  // Multiplier bits are taken most significant first.
  always_comb begin
    acc_next = {acc[38:0], 1'b0};
    if (mreg[7]) begin
      acc_next = acc_next + {8'd0, base};
    end
  end

  // Step through the multiplier, then clamp to the minimum and to 32 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        base <= (period != 32'd0) ? period : min_ticks;
        mreg <= mult;
        acc  <= '0;
        cnt  <= 4'(MULT_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc_next;
        mreg <= {mreg[6:0], 1'b0};
        cnt  <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (acc_next < {8'd0, min_ticks}) begin
            window <= min_ticks;
          end else if (acc_next[39:32] != 8'd0) begin
            window <= '1;
          end else begin
            window <= acc_next[31:0];
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pwm_period_duty_capture.sv
// Top level of the PWM period and duty capture block: channel state, sequencer
// and output register. Depends on pdc_pkg, pdc_div and pdc_window.
//
// Usage: each input word on the s_ channel is either an edge capture (mode 0)
// on channel chan or a timer overflow tick (mode 1), with the counter value in
// s_tdata. Configuration writes on the cfg_ channel set the timeout multiplier
// (index 0) and the minimum timeout window (index 1); cfg_ready is always high.
// A rising edge gives no result; the next word is taken only once the 8-step
// serial multiplier has formed the timeout window.
// A falling edge gives one result after 16 divider steps for the duty value and
// then the window. When the high time reaches the period or the period is zero
// the divider finishes at once. An overflow tick gives one result for each
// timed-out channel, and the last result of a word carries m_tlast.
// Results sit in an output register, so a new word is accepted while a result
// waits; when the receiver stalls and a second result is due, the sequencer
// holds until the register frees, and s_tready stays low meanwhile.
// Reset (rst, synchronous) clears all channel state, the overflow count and
// the registers to their defaults, and empties the output register.
module pwm_period_duty_capture import pdc_pkg::*; #(
  parameter int NUM_CHANNELS = 2,
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // count_value[15:0]
  input  logic [1:0]  s_tuser,   // mode[0], chan[1]
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // duty_q16[16:0], period_len[48:17], zero fill
  output logic [1:0]  m_tuser,   // out_chan[0], timed_out[1]
  output logic        m_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [7:0]  timeout_mult;
  logic [31:0] min_timeout;

  // Channel state.
  logic [15:0] overflow_count;
  logic [31:0] rise_time    [NUM_CHANNELS];
  logic [31:0] period_store [NUM_CHANNELS];
  logic [31:0] deadline     [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] armed;
  logic [NUM_CHANNELS-1:0] await_fall;

  // Latched word and work registers.
  logic                    ch;
  logic [COUNTER_BITS-1:0] count_reg;
  logic                    is_fall;
  logic [31:0]             ts;
  logic [16:0]             duty;
  logic [NUM_CHANNELS-1:0] mask;

  // Output register.
  logic        out_valid;
  logic        out_chan;
  logic [16:0] out_duty;
  logic [31:0] out_period;
  logic        out_timed;
  logic        out_last;

  // Sequencer strobes.
  logic accept;
  logic div_start;
  logic win_start;
  logic load_edge;
  logic load_scan;
  logic out_free;

  // Combinational helpers.
  logic                    in_mode;
  logic                    in_chan;
  logic                    chan_ok;
  logic                    sel_ch;
  logic [31:0]             ts_in;
  logic [31:0]             now;
  logic [31:0]             sel_rise;
  logic [31:0]             sel_period;
  logic                    sel_await;
  logic                    sel_armed;
  logic [NUM_CHANNELS-1:0] hit;
  logic [IW-1:0]           lo;
  logic [NUM_CHANNELS-1:0] mask_clr;

  logic        div_done;
  logic [16:0] div_quot;
  logic        win_done;
  logic [31:0] win_value;

  assign in_mode   = s_tuser[0];
  assign in_chan   = s_tuser[1];
  assign chan_ok   = (int'(in_chan) < NUM_CHANNELS);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;

  // Timestamps: the overflow count extends the counter value.
  assign ts_in = 32'({overflow_count, s_tdata[COUNTER_BITS-1:0]});
  assign now   = 32'({overflow_count, count_reg});

  // Per-channel selection; the input channel is used while a word is taken.
  assign sel_ch = (state == S_IDLE) ? in_chan : ch;
  always_comb begin
    sel_rise   = '0;
    sel_period = '0;
    sel_await  = 1'b0;
    sel_armed  = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (c == int'(sel_ch)) begin
        sel_rise   = rise_time[c];
        sel_period = period_store[c];
        sel_await  = await_fall[c];
        sel_armed  = armed[c];
      end
    end
  end

  // Deadline check of every channel at an overflow tick.
  always_comb begin
    logic [31:0] diff;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      diff   = now - deadline[c];
      hit[c] = armed[c] && !diff[31];
    end
  end

  // Lowest pending timeout, and whether it is the final one.
  always_comb begin
    lo = '0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (mask[c]) begin
        lo = IW'(c);
      end
    end
    mask_clr = mask;
    mask_clr[lo] = 1'b0;
  end

  pdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ts_in - sel_rise),
    .divisor  (sel_period),
    .done     (div_done),
    .quot     (div_quot)
  );

  pdc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .start     (win_start),
    .period    (sel_period),
    .mult      (timeout_mult),
    .min_ticks (min_timeout),
    .done      (win_done),
    .window    (win_value)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer strobes.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    div_start  = 1'b0;
    win_start  = 1'b0;
    load_edge  = 1'b0;
    load_scan  = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept = 1'b1;
          if (in_mode == MODE_TICK) begin
            state_next = S_TICK;
          end else if (chan_ok) begin
            if (sel_await) begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end else begin
              state_next = S_WSTART;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WSTART;
        end
      end
      S_WSTART: begin
        win_start  = 1'b1;
        state_next = S_WIN;
      end
      S_WIN: begin
        if (win_done) begin
          state_next = is_fall ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_edge  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (mask == '0) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          load_scan = 1'b1;
          if (mask_clr == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_mult <= MULT_RESET;
      min_timeout  <= MIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT_MULT: timeout_mult <= cfg_data[7:0];
        CFG_MIN_TIMEOUT:  min_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count <= '0;
      armed          <= '0;
      await_fall     <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        rise_time[c]    <= '0;
        period_store[c] <= '0;
        deadline[c]     <= '0;
      end
    end else begin
      // Take a word: tick bumps the overflow count, an edge updates its channel.
      if (accept) begin
        ch        <= in_chan;
        count_reg <= s_tdata[COUNTER_BITS-1:0];
        ts        <= ts_in;
        is_fall   <= sel_await;
        if (in_mode == MODE_TICK) begin
          overflow_count <= overflow_count + 16'd1;
        end else if (chan_ok) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c == int'(in_chan)) begin
              if (sel_await) begin
                await_fall[c] <= 1'b0;
              end else begin
                if (sel_armed) begin
                  period_store[c] <= ts_in - sel_rise;
                end
                rise_time[c]  <= ts_in;
                armed[c]      <= 1'b1;
                await_fall[c] <= 1'b1;
              end
            end
          end
        end
      end
      if (div_done) begin
        duty <= div_quot;
      end
      // New deadline once the window is ready.
      if (win_done) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (c == int'(ch)) begin
            deadline[c] <= ts + win_value;
          end
        end
      end
      // Timed-out channels return to their idle state.
      if (state == S_TICK) begin
        mask <= hit;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (hit[c]) begin
            armed[c]        <= 1'b0;
            await_fall[c]   <= 1'b0;
            period_store[c] <= '0;
          end
        end
      end
      if (load_scan) begin
        mask <= mask_clr;
      end
    end
  end

  // Output register: loads a result word, empties when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (load_edge) begin
        out_valid  <= 1'b1;
        out_chan   <= ch;
        out_duty   <= duty;
        out_period <= sel_period;
        out_timed  <= 1'b0;
        out_last   <= 1'b1;
      end else if (load_scan) begin
        out_valid  <= 1'b1;
        out_chan   <= lo[0];
        out_duty   <= '0;
        out_period <= '0;
        out_timed  <= 1'b1;
        out_last   <= (mask_clr == '0);
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_period, out_duty};
  assign m_tuser  = {out_timed, out_chan};
  assign m_tlast  = out_last;

endmodule

FILE: test/pwm_period_duty_capture_test.sv
// Self-checking testbench for pwm_period_duty_capture: drives edge captures and
// overflow ticks as stream words, predicts period, duty and timeout results, and
// checks every result word. Depends on pdc_pkg and the block's RTL.
`timescale 1ns / 100ps

module pwm_period_duty_capture_test;
  import pdc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_PHASES   = 12;

  // One input word and one result word as the block sees them.
  typedef struct packed {
    logic        mode;
    logic        chan;
    logic [15:0] count;
  } capture_word_t;

  typedef struct packed {
    logic        chan;
    logic [16:0] duty;
    logic [31:0] period;
    logic        timed_out;
    logic        last;
  } capture_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // count_value[15:0]
  logic [1:0]  s_tuser;   // mode[0], chan[1]
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // duty_q16[16:0], period_len[48:17], zero fill
  logic [1:0]  m_tuser;   // out_chan[0], timed_out[1]
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  pwm_period_duty_capture dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Words waiting to be sent and results the block still owes.
  capture_word_t   pending_words[$];
  capture_result_t capture_results_due[$];
  int              mismatches;

  // Predicted block state and register copies.
  logic [7:0]  mult_cfg;
  logic [31:0] min_cfg;
  logic [15:0] tick_count;
  logic [31:0] rise_stamp[2];
  logic [31:0] period_meas[2];
  logic [31:0] deadline_at[2];
  logic        armed_ch[2];
  logic        await_fall_ch[2];

  // Idle control shared between the sequence and the two stream processes.
  bit src_quiet;
  bit sink_quiet;
  int hold_requests;

  // Waveform generator state, in extended timer ticks.
  int     gen_epoch;
  longint stim_time;
  longint next_edge[2];
  bit     level_hi[2];
  int     wave_per[2];
  int     wave_high[2];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Deadline window: period, or the minimum when no period is known, times the
  // multiplier, clamped between the minimum and all ones.
  function automatic logic [31:0] timeout_window(logic [31:0] per);
    logic [31:0] base;
    logic [39:0] w;
    base = (per != 32'd0) ? per : min_cfg;
    w = {8'd0, base} * {32'd0, mult_cfg};
    if (w < {8'd0, min_cfg})
      w = {8'd0, min_cfg};
    else if (w > 40'hFF_FFFF_FFFF >> 8)
      w = 40'h00_FFFF_FFFF;
    return w[31:0];
  endfunction

  // Update the predicted state for one accepted word and queue its results.
  task automatic capture_predict(input capture_word_t w);
    logic [31:0]     now;
    logic [31:0]     diff;
    logic [31:0]     high;
    logic [47:0]     quot;
    capture_result_t r;
    int              first_new;
    first_new = capture_results_due.size();
    if (w.mode == MODE_TICK) begin
      tick_count = tick_count + 16'd1;
      now = {tick_count, w.count};
      for (int c = 0; c < 2; c++) begin
        diff = now - deadline_at[c];
        if (armed_ch[c] && !diff[31]) begin
          armed_ch[c] = 1'b0;
          await_fall_ch[c] = 1'b0;
          period_meas[c] = 32'd0;
          r = '{c[0], 17'd0, 32'd0, 1'b1, 1'b0};
          capture_results_due.push_back(r);
        end
      end
      // Only the final result of a tick carries the last flag.
      if (capture_results_due.size() > first_new)
        capture_results_due[capture_results_due.size() - 1].last = 1'b1;
    end else begin
      now = {tick_count, w.count};
      if (await_fall_ch[w.chan]) begin
        await_fall_ch[w.chan] = 1'b0;
        high = now - rise_stamp[w.chan];
        r = '{w.chan, 17'd0, period_meas[w.chan], 1'b0, 1'b1};
        if (period_meas[w.chan] != 32'd0) begin
          quot = {high, 16'd0} / {16'd0, period_meas[w.chan]};
          r.duty = (quot > 48'h1_0000) ? DUTY_ONE : quot[16:0];
        end
        capture_results_due.push_back(r);
      end else begin
        if (armed_ch[w.chan])
          period_meas[w.chan] = now - rise_stamp[w.chan];
        rise_stamp[w.chan] = now;
        armed_ch[w.chan] = 1'b1;
        await_fall_ch[w.chan] = 1'b1;
      end
      deadline_at[w.chan] = now + timeout_window(period_meas[w.chan]);
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Queue a word; a tick also moves the generator into the next timer epoch.
  function automatic void queue_word(logic mode, logic chan, logic [15:0] cnt);
    capture_word_t w;
    w = '{mode, chan, cnt};
    pending_words.push_back(w);
    if (mode == MODE_TICK) begin
      gen_epoch++;
      stim_time = (longint'(gen_epoch) << 16) | longint'(cnt);
    end
  endfunction

  // New period and high time for one channel: short, medium or long class.
  function automatic void pick_waveform(int c);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      wave_per[c] = $urandom_range(8, 3000);
    else if (r < 8)
      wave_per[c] = $urandom_range(3000, 70000);
    else
      wave_per[c] = $urandom_range(70000, 300000);
    wave_high[c] = $urandom_range(0, wave_per[c]);
  endfunction

  // Plan n words of two jittered PWM signals in time order, with overflow ticks
  // at every epoch boundary, occasional signal loss and some random noise.
  task automatic plan_pwm(input int n);
    longint tick_at;
    int     c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
      end else begin
        tick_at = (longint'(gen_epoch) + 1) << 16;
        for (int k = 0; k < 2; k++)
          if (next_edge[k] < stim_time)
            next_edge[k] = stim_time;
        c = (next_edge[1] < next_edge[0]) ? 1 : 0;
        if (next_edge[c] >= tick_at) begin
          queue_word(MODE_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 3)));
        end else begin
          stim_time = next_edge[c];
          queue_word(MODE_EDGE, c[0], stim_time[15:0]);
          if (!level_hi[c])
            next_edge[c] = stim_time + wave_high[c];
          else
            next_edge[c] = stim_time + (wave_per[c] - wave_high[c]);
          next_edge[c] += $urandom_range(0, wave_per[c] / 8);
          level_hi[c] = !level_hi[c];
          // Signal loss: go quiet for a long stretch that may trip the timeout, then restart.
          if ($urandom_range(0, 39) == 0) begin
            next_edge[c] = stim_time + $urandom_range(65536, 500000);
            level_hi[c] = 1'b0;
            if ($urandom_range(0, 1) == 0)
              pick_waveform(c);
          end
        end
      end
    end
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIMEOUT_MULT)
      mult_cfg = val[7:0];
    else
      min_cfg = val;
  endtask

  // Wait until all words are sent and all results are in, then let the block settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || capture_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: hold the word until accepted, predict it, then maybe pause.
  capture_word_t cur_word;
  int            src_gap;

  always @(posedge clk) begin : sender
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        capture_predict(cur_word);
        nv = 1'b0;
        src_gap = src_quiet ? 0 : pick_gap();
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          nv = 1'b1;
          s_tdata <= cur_word.count;
          s_tuser <= {cur_word.chan, cur_word.mode};
        end
      end
      s_tvalid <= nv;
    end
  end

  // Receiver: check each accepted result against the oldest prediction, and
  // stall at random or for a long hold when one is requested.
  int hold_left;
  int holds_started;
  int stall_left;

  always @(posedge clk) begin : receiver
    capture_result_t got;
    capture_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      holds_started = 0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tuser[0], m_tdata[16:0], m_tdata[48:17], m_tuser[1], m_tlast};
        if (capture_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word chan %0d duty %0d period %0d tout %0d last %0d",
                                  got.chan, got.duty, got.period, got.timed_out, got.last));
        end else begin
          want = capture_results_due.pop_front();
          if (got.chan != want.chan || got.duty != want.duty || got.period != want.period ||
              got.timed_out != want.timed_out || got.last != want.last)
            flag_mismatch($sformatf(
              "chan %0d/%0d duty %0d/%0d period %0d/%0d tout %0d/%0d last %0d/%0d (got/exp)",
              got.chan, want.chan, got.duty, want.duty, got.period, want.period,
              got.timed_out, want.timed_out, got.last, want.last));
        end
      end
      if (hold_left > 0)
        hold_left--;
      else if (holds_started < hold_requests) begin
        holds_started++;
        hold_left = LONG_HOLD;
      end else if (stall_left > 0)
        stall_left--;
      else if (!sink_quiet && $urandom_range(0, 7) == 0)
        stall_left = pick_gap();
      m_tready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // Run limit.
  int unsigned cycle_count;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sequence: reset, directed words, then random phases under several settings.
  initial begin : sequence_main
    logic [7:0]  mult_v;
    logic [31:0] min_v;
    int          n_words;
    bit          hold_v;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIMEOUT_MULT;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_requests = 0;
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    mult_cfg = MULT_RESET;
    min_cfg = MIN_RESET;
    tick_count = '0;
    for (int c = 0; c < 2; c++) begin
      rise_stamp[c] = '0;
      period_meas[c] = '0;
      deadline_at[c] = '0;
      armed_ch[c] = 1'b0;
      await_fall_ch[c] = 1'b0;
    end
    gen_epoch = 0;
    stim_time = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: tick with nothing armed, zero period, full and partial duty,
    // saturation, zero high time, a tick that times out one channel, a tick
    // short of the deadline, and a rise after a timeout.
    queue_word(MODE_TICK, 1'b1, 16'hFFFF);
    queue_word(MODE_EDGE, 1'b0, 16'h0000);
    queue_word(MODE_EDGE, 1'b0, 16'h0010);
    queue_word(MODE_EDGE, 1'b0, 16'h0100);
    queue_word(MODE_EDGE, 1'b0, 16'h0200);
    queue_word(MODE_EDGE, 1'b0, 16'h0200);
    queue_word(MODE_EDGE, 1'b0, 16'h0240);
    queue_word(MODE_EDGE, 1'b0, 16'h0300);
    queue_word(MODE_EDGE, 1'b0, 16'h0500);
    queue_word(MODE_EDGE, 1'b1, 16'hFFFF);
    queue_word(MODE_EDGE, 1'b1, 16'hFFFF);
    queue_word(MODE_TICK, 1'b0, 16'h0000);
    queue_word(MODE_TICK, 1'b1, 16'h8000);
    queue_word(MODE_EDGE, 1'b1, 16'h1234);
    queue_word(MODE_TICK, 1'b0, 16'h0000);
    queue_word(MODE_TICK, 1'b0, 16'h5555);
    queue_word(MODE_EDGE, 1'b0, 16'hAAAA);

    for (int c = 0; c < 2; c++) begin
      pick_waveform(c);
      level_hi[c] = 1'b0;
      next_edge[c] = stim_time + $urandom_range(0, 5000);
    end

    // Random phases; the register settings include both extremes and zero.
    for (int p = 0; p < NUM_PHASES; p++) begin
      hold_v = 1'b0;
      src_quiet = 1'b0;
      sink_quiet = 1'b0;
      n_words = 130;
      case (p)
        0: begin mult_v = MULT_RESET; min_v = MIN_RESET; n_words = 240; end
        1: begin mult_v = 8'd255; min_v = 32'd1; n_words = 200; hold_v = 1'b1; end
        2: begin mult_v = 8'd1; min_v = 32'hFFFF_FFFF; end
        3: begin mult_v = 8'd0; min_v = 32'd1000; end
        4: begin mult_v = 8'd7; min_v = 32'd0; hold_v = 1'b1; end
        5: begin mult_v = 8'd0; min_v = 32'd0; n_words = 100; end
        default: begin
          mult_v = 8'($urandom_range(0, 255));
          min_v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 300000);
        end
      endcase
      wait_idle();
      write_reg(CFG_TIMEOUT_MULT, {24'd0, mult_v});
      write_reg(CFG_MIN_TIMEOUT, min_v);
      // Long receiver holds come with a sender that never pauses, so the block
      // backs up; one phase runs with no idling on either side.
      if (hold_v) begin
        src_quiet = 1'b1;
        hold_requests++;
      end
      if (p == 2) begin
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
      end
      plan_pwm(n_words);
    end
    wait_idle();

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
